// ===== rtl/core/sle_pkg.sv =====
// Package: shared types, constants and helpers of the sprite line evaluation block.
package sle_pkg;

  localparam int unsigned SpriteSlots = 128;
  localparam int unsigned LineSprites = 32;
  localparam int unsigned LineSlivers = 34;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    OpWriteWord = 2'd0,
    OpWriteHigh = 2'd1,
    OpEvaluate  = 2'd2,
    OpNone      = 2'd3
  } op_e;

  localparam logic CfgExtraLeft  = 1'b0;
  localparam logic CfgExtraRight = 1'b1;

  // One classified item handed from the front to the back
  typedef struct packed {
    op_e         op;
    logic [7:0]  address;
    logic [15:0] write_data;
    logic [7:0]  line;
    logic [7:0]  object_select;
    logic [7:0]  start_word;
    logic        active;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic              kind;
    logic signed [9:0] sliver_x;
    logic [7:0]        line_out;
    logic [10:0]       tile_number;
    logic [2:0]        char_row;
    logic [7:0]        pal_base;
    logic [1:0]        priority_res;
    logic              flip_horizontal;
    logic [6:0]        sprite_slot;
    logic              color_math;
    logic [1:0]        overflow_flags;
    logic [3:0]        priority_mask;
  } res_t;

  // Sprite size in pixels for a size pair and the size bit
  function automatic logic [6:0] size_lookup(input logic [2:0] pair, input logic big);
    logic [6:0] s;
    unique case (pair)
      3'd0:    s = big ? 7'd16 : 7'd8;
      3'd1:    s = big ? 7'd32 : 7'd8;
      3'd2:    s = big ? 7'd64 : 7'd8;
      3'd3:    s = big ? 7'd32 : 7'd16;
      3'd4:    s = big ? 7'd64 : 7'd16;
      3'd5:    s = big ? 7'd64 : 7'd32;
      default: s = big ? 7'd32 : 7'd16;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/sle_front.sv =====
// Front: accepts input items, classifies them and queues them for the back.
module sle_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [55:0]    s_axis_tdata,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output sle_pkg::cmd_t  cmd_o
);

  localparam int unsigned PtrW = $clog2(sle_pkg::QueueDepth);

  sle_pkg::cmd_t            mem_q [sle_pkg::QueueDepth];
  logic [PtrW-1:0]          wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]            cnt_q, cnt_d;
  sle_pkg::cmd_t            cmd_in;
  logic                     push, pop;

  // Classify the raw fields
  always_comb begin
    cmd_in.op            = sle_pkg::op_e'(s_axis_tdata[1:0]);
    cmd_in.address       = s_axis_tdata[9:2];
    cmd_in.write_data    = s_axis_tdata[25:10];
    cmd_in.line          = s_axis_tdata[33:26];
    cmd_in.object_select = s_axis_tdata[41:34];
    cmd_in.start_word    = s_axis_tdata[50] ? {s_axis_tdata[49:43], 1'b0} : 8'd0;
    cmd_in.active        = s_axis_tdata[51];
  end

  assign s_axis_tready = (cnt_q != (PtrW+1)'(sle_pkg::QueueDepth));
  // Unused operation never enters the queue
  assign push = s_axis_tvalid && s_axis_tready && (cmd_in.op != sle_pkg::OpNone);
  assign cmd_valid_o = (cnt_q != '0);
  assign pop  = cmd_valid_o && cmd_ready_i;
  assign cmd_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? PtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? PtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

`ifndef SYNTH
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(sle_pkg::QueueDepth)) else $error("queue overfilled");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (PtrW+1)'(sle_pkg::QueueDepth)) |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (cnt_q != '0)) else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/core/sle_back.sv =====
// Back: attribute memories, range walk, sliver fetch and result register.
module sle_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  sle_pkg::cmd_t  cmd_i,
  input  logic [5:0]     extra_left_i,
  input  logic [5:0]     extra_right_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output sle_pkg::res_t  res_o
);

  typedef enum logic [2:0] {
    StIdle, StRead, StRange, StFetchRd, StFetchWait, StSliver, StEnd
  } state_e;

  state_e         state_q;
  sle_pkg::cmd_t  cmd_q;
  logic [7:0]     w_q;          // current word index (even)
  logic [7:0]     walk_q;       // sprites left to walk
  logic [5:0]     kept_q;       // kept count, later fetch index
  logic [5:0]     slivers_q;
  logic [1:0]     flags_q;
  logic [3:0]     pmask_q;
  logic [6:0]     col_q;
  logic           res_valid_q;
  sle_pkg::res_t  res_q;

  // Word memory, split in even (Y/X) and odd (attributes) halves
  logic [15:0]    even_mem [128];
  logic [15:0]    odd_mem  [128];
  logic [127:0]   even_vld_q, odd_vld_q;
  logic [7:0]     high_q [32];
  logic [7:0]     kept_mem [32];
  logic [15:0]    w0_rd_q, w1_rd_q;
  logic           w0_vld_q, w1_vld_q;
  logic [6:0]     rd_idx;
  logic [7:0]     kept_rd_q;

  wire [15:0] w0 = w0_vld_q ? w0_rd_q : 16'd0;
  wire [15:0] w1 = w1_vld_q ? w1_rd_q : 16'd0;

  // Per sprite quantities of the word at w_q
  logic [7:0]        hb;
  logic              xbit, size_big;
  logic [6:0]        sz;
  logic signed [10:0] x;
  logic [7:0]        row;
  logic              in_range;
  logic signed [10:0] sx;
  logic              visible;
  logic [6:0]        ucol;
  logic [7:0]        row_f;
  logic [3:0]        tr, tc;
  logic [14:0]       word;
  logic [14:0]       adr1, adr2, base;
  sle_pkg::res_t     sliver_res, end_res;
  logic              out_free, sliver_go, res_load;

  always_comb begin
    hb    = high_q[w_q[7:3]];
    xbit  = hb[{w_q[2:1], 1'b0}];
    size_big = hb[{w_q[2:1], 1'b1}];
    sz    = sle_pkg::size_lookup(cmd_q.object_select[7:5], size_big);
    x     = {2'b00, xbit, w0[7:0]};
    if ({1'b0, xbit, w0[7:0]} >= 10'd256 + 10'(extra_right_i)) x = x - 11'sd512;
    row   = cmd_q.line - w0[15:8];
    in_range = ({1'b0, row} < {1'b0, sz}) &&
               (x + $signed({4'd0, sz}) > -$signed({5'd0, extra_left_i}));
    sx    = x + $signed({4'd0, col_q});
    visible = !(sx <= -11'sd8 - $signed({5'd0, extra_left_i}) ||
                sx >= 11'sd256 + $signed({5'd0, extra_right_i}));
    ucol  = w1[14] ? 7'(sz - 7'd1 - col_q) : col_q;
    row_f = w1[15] ? 8'(8'(sz) - 8'd1 - row) : row;
    tr    = 4'(w1[7:4] + row_f[6:3]);
    tc    = 4'(w1[3:0] + ucol[6:3]);
    // Name base and second table, word address wraps at 15 bits
    adr1  = {cmd_q.object_select[1:0], 13'd0};
    adr2  = adr1 + {({1'b0, cmd_q.object_select[4:3]} + 3'd1), 12'd0};
    base  = w1[8] ? adr2 : adr1;
    word  = 15'(base + {3'd0, tr, tc, 4'd0});
    // Assemble the sliver and the end-of-line items
    sliver_res = '0;
    sliver_res.sliver_x        = 10'(sx);
    sliver_res.line_out        = cmd_q.line;
    sliver_res.tile_number     = word[14:4];
    sliver_res.char_row        = row_f[2:0];
    sliver_res.pal_base        = {1'b1, w1[11:9], 4'd0};
    sliver_res.priority_res    = w1[13:12];
    sliver_res.flip_horizontal = w1[14];
    sliver_res.sprite_slot     = w_q[7:1];
    sliver_res.color_math      = w1[11];
    end_res = '0;
    end_res.kind           = 1'b1;
    end_res.line_out       = cmd_q.line;
    end_res.overflow_flags = flags_q;
    end_res.priority_mask  = pmask_q;
  end

  assign out_free  = !res_valid_q || res_ready_i;
  assign sliver_go = (state_q == StSliver) && (col_q < sz) && visible &&
                     (slivers_q < 6'(sle_pkg::LineSlivers));
  assign res_load  = out_free && (sliver_go || state_q == StEnd);

  assign rd_idx = (state_q == StFetchWait) ? kept_rd_q[7:1] : w_q[7:1];
  assign cmd_ready_o = (state_q == StIdle) && !res_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  // Memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && cmd_valid_i && cmd_ready_o) begin
      if (cmd_i.op == sle_pkg::OpWriteWord) begin
        if (cmd_i.address[0]) odd_mem[cmd_i.address[7:1]] <= cmd_i.write_data;
        else even_mem[cmd_i.address[7:1]] <= cmd_i.write_data;
      end
    end
    w0_rd_q <= even_mem[rd_idx];
    w1_rd_q <= odd_mem[rd_idx];
    kept_rd_q <= kept_mem[5'(kept_q - 6'd1)];
    if (state_q == StRange && in_range && kept_q < 6'(sle_pkg::LineSprites)) begin
      kept_mem[kept_q[4:0]] <= w_q;
    end
  end

  // Control, valid bits, high bytes and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      even_vld_q  <= '0;
      odd_vld_q   <= '0;
      for (int i = 0; i < 32; i++) high_q[i] <= '0;
      res_valid_q <= 1'b0;
      w0_vld_q    <= 1'b0;
      w1_vld_q    <= 1'b0;
      cmd_q       <= '0;
      w_q <= '0; walk_q <= '0; kept_q <= '0; slivers_q <= '0;
      flags_q <= '0; pmask_q <= '0; col_q <= '0; res_q <= '0;
    end else begin
      w0_vld_q <= even_vld_q[rd_idx];
      w1_vld_q <= odd_vld_q[rd_idx];
      if (res_load) res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (cmd_valid_i && cmd_ready_o) begin
            cmd_q <= cmd_i;
            unique case (cmd_i.op)
              sle_pkg::OpWriteWord: begin
                if (cmd_i.address[0]) odd_vld_q[cmd_i.address[7:1]] <= 1'b1;
                else even_vld_q[cmd_i.address[7:1]] <= 1'b1;
              end
              sle_pkg::OpWriteHigh: high_q[cmd_i.address[4:0]] <= cmd_i.write_data[7:0];
              sle_pkg::OpEvaluate: begin
                w_q <= cmd_i.start_word; walk_q <= 8'(sle_pkg::SpriteSlots);
                kept_q <= '0; slivers_q <= '0; flags_q <= '0; pmask_q <= '0;
                state_q <= cmd_i.active ? StRead : StEnd;
              end
              default: ;
            endcase
          end
        end
        // Read settles the word memory at w_q
        StRead: state_q <= StRange;
        StRange: begin
          if (in_range && kept_q >= 6'(sle_pkg::LineSprites)) begin
            flags_q[0] <= 1'b1;
            state_q <= (kept_q == 0) ? StEnd : StFetchRd;
          end else begin
            if (in_range) kept_q <= kept_q + 6'd1;
            w_q <= w_q + 8'd2;
            walk_q <= walk_q - 8'd1;
            if (walk_q == 8'd1)
              state_q <= (kept_q == 0 && !in_range) ? StEnd : StFetchRd;
            else state_q <= StRead;
          end
        end
        // Kept index read settles here
        StFetchRd: state_q <= StFetchWait;
        // Latch the kept index and read its words
        StFetchWait: begin
          w_q <= kept_rd_q; col_q <= '0;
          state_q <= StSliver;
        end
        StSliver: begin
          if (out_free) begin
            if (col_q >= sz) begin
              kept_q <= kept_q - 6'd1;
              state_q <= (kept_q == 6'd1) ? StEnd : StFetchRd;
            end else if (!visible) begin
              col_q <= col_q + 7'd8;
            end else if (slivers_q >= 6'(sle_pkg::LineSlivers)) begin
              flags_q[1] <= 1'b1;
              state_q <= StEnd;
            end else begin
              slivers_q <= slivers_q + 6'd1;
              col_q <= col_q + 7'd8;
              pmask_q <= pmask_q | (4'd1 << w1[13:12]);
              res_q <= sliver_res;
            end
          end
        end
        StEnd: begin
          if (out_free) begin
            res_q <= end_res;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTH
  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= 6'(sle_pkg::LineSprites)) else $error("kept count too large");
  a_sliver_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slivers_q <= 6'(sle_pkg::LineSlivers)) else $error("sliver count too large");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_ready_i) |=> res_valid_q && $stable(res_q))
    else $error("result dropped");
`endif

endmodule

// ===== rtl/core/sprite_line_evaluation.sv =====
// Top level: sprite line evaluation with attribute memory and sliver output.
// An evaluate item walks up to 128 sprite slots, each through a read state and
// a range state since the attribute memory read is registered, then fetches
// each kept sprite and emits a sliver per visible eight-pixel column. Results
// come one per cycle at most with sliver items first, then the end-of-line
// item with tlast high.
module sprite_line_evaluation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation, address, write_data, line, object_select, start_address,
  // rotate_enable, sprites_active
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sliver_x, line_out, tile_number, char_row, pal_base, priority_res,
  // flip_horizontal, sprite_slot, color_math, overflow_flags, priority_mask
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [5:0]  cfg_data_i
);

  logic          cmd_valid, cmd_ready;
  sle_pkg::cmd_t cmd;
  sle_pkg::res_t res;
  logic [5:0]    extra_left_q, extra_right_q;

  assign cfg_ready_o = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_left_q  <= '0;
      extra_right_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == sle_pkg::CfgExtraLeft) extra_left_q <= cfg_data_i;
      else extra_right_q <= cfg_data_i;
    end
  end

  sle_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  sle_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .extra_left_i(extra_left_q), .extra_right_i(extra_right_q),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tlast = res.kind;
  assign m_axis_tdata = {7'd0, res.priority_mask, res.overflow_flags, res.color_math,
                         res.sprite_slot, res.flip_horizontal, res.priority_res,
                         res.pal_base, res.char_row, res.tile_number,
                         res.line_out, res.sliver_x};

endmodule
